/* sv/kf2_pkg.sv */
// Package for the two-state Kalman filter: widths, codes, reset values and
// saturating fixed-point helpers. Depends on nothing.
package kf2_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_WIDTH  = 31;
	localparam int MUL_STEPS  = DATA_WIDTH;
	localparam int DIV_STEPS  = DATA_WIDTH + FRAC_BITS;
	localparam int CNT_WIDTH  = $clog2(DIV_STEPS);

	typedef logic signed [DATA_WIDTH-1:0] fx_t;

	localparam fx_t FX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam fx_t FX_ONE = fx_t'(1) <<< FRAC_BITS;
	localparam fx_t FX_ZERO = '0;

	typedef enum logic [1:0] {
		KIND_PREDICT = 2'd0,
		KIND_UPDATE  = 2'd1,
		KIND_INIT    = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_TIME_STEP  = 3'd0,
		REG_MEAS_NOISE = 3'd1,
		REG_Q_POS      = 3'd2,
		REG_Q_CROSS    = 3'd3,
		REG_Q_BIAS     = 3'd4,
		REG_P0_POS     = 3'd5,
		REG_P0_CROSS   = 3'd6,
		REG_P0_BIAS    = 3'd7
	} reg_idx_t;

	// Operation handed to a serial arithmetic unit.
	typedef struct packed {
		logic start;
		fx_t  a;
		fx_t  b;
	} op_t;

	// Result coming back from a serial arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
		fx_t  value;
	} res_t;

	function automatic fx_t sat_add(fx_t a, fx_t b);
		logic [DATA_WIDTH:0] s;
		s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) return s[DATA_WIDTH] ? FX_MIN : FX_MAX;
		return fx_t'(s[DATA_WIDTH-1:0]);
	endfunction

	function automatic fx_t sat_sub(fx_t a, fx_t b);
		logic [DATA_WIDTH:0] s;
		s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) return s[DATA_WIDTH] ? FX_MIN : FX_MAX;
		return fx_t'(s[DATA_WIDTH-1:0]);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] mag(fx_t v);
		return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// Signed result from a sign, an overflow flag and a magnitude, saturated.
	function automatic fx_t from_mag(logic neg, logic big, logic [DATA_WIDTH-1:0] m);
		if (!neg) return (big || m[DATA_WIDTH-1]) ? FX_MAX : fx_t'(m);
		if (big || m > {1'b1, {(DATA_WIDTH-1){1'b0}}}) return FX_MIN;
		return fx_t'(~m + 1'b1);
	endfunction

endpackage

/* sv/kf2_if.sv */
// Handshake channels of the two-state Kalman filter: input items, result
// items and configuration writes. Depends on kf2_pkg.
interface kf2_in_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           kind;
	kf2_pkg::fx_t         measurement;
	kf2_pkg::fx_t         init_pos;
	kf2_pkg::fx_t         init_bias;
	modport source(output valid, kind, measurement, init_pos, init_bias, input ready);
	modport sink(input valid, kind, measurement, init_pos, init_bias, output ready);
endinterface

interface kf2_out_if;
	logic         valid;
	logic         ready;
	kf2_pkg::fx_t est_pos;
	kf2_pkg::fx_t est_bias;
	kf2_pkg::fx_t cov_pos;
	kf2_pkg::fx_t cov_cross;
	kf2_pkg::fx_t cov_bias;
	modport source(output valid, est_pos, est_bias, cov_pos, cov_cross, cov_bias, input ready);
	modport sink(input valid, est_pos, est_bias, cov_pos, cov_cross, cov_bias, output ready);
endinterface

interface kf2_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* sv/kf2_mul.sv */
// Bit-serial fixed-point multiplier, one multiplier bit per cycle, with
// truncation of the fraction and saturation. Depends on kf2_pkg.
module kf2_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  kf2_pkg::op_t  op,
	output kf2_pkg::res_t res
);
	localparam int W = kf2_pkg::DATA_WIDTH;
	localparam int F = kf2_pkg::FRAC_BITS;

	logic                              busy_q;
	logic                              done_q;
	logic [kf2_pkg::CNT_WIDTH-1:0]     cnt_q;
	logic [2*W-1:0]                    acc_q;
	logic [W-1:0]                      ma_q;
	logic [W-1:0]                      mb_q;
	logic                              neg_q;
	kf2_pkg::fx_t                      val_q;
	logic [W:0]                        sum;
	logic [2*W-1:0]                    acc_nxt;

	always_comb begin
		sum     = {1'b0, acc_q[2*W-1:W]} + (mb_q[0] ? {1'b0, ma_q} : '0);
		acc_nxt = {sum, acc_q[W-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (op.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == kf2_pkg::CNT_WIDTH'(kf2_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.start && !busy_q) begin
			acc_q <= '0;
			ma_q  <= kf2_pkg::mag(op.a);
			mb_q  <= kf2_pkg::mag(op.b);
			neg_q <= op.a[W-1] ^ op.b[W-1];
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			mb_q  <= mb_q >> 1;
			val_q <= kf2_pkg::from_mag(neg_q, |acc_nxt[2*W-1:W+F], acc_nxt[W+F-1:F]);
		end
	end

	assign res = '{busy: busy_q, done: done_q, value: val_q};
endmodule

/* sv/kf2_div.sv */
// Restoring divider giving (n << FRAC_BITS) / d, one quotient bit per cycle,
// truncated toward zero and saturated. Depends on kf2_pkg.
module kf2_div (
	input  logic          clk,
	input  logic          arst_n,
	input  kf2_pkg::op_t  op,
	output kf2_pkg::res_t res
);
	localparam int W = kf2_pkg::DATA_WIDTH;
	localparam int N = kf2_pkg::DIV_STEPS;

	logic                          busy_q;
	logic                          done_q;
	logic [kf2_pkg::CNT_WIDTH-1:0] cnt_q;
	logic [N-1:0]                  dsr_q;
	logic [N-1:0]                  quo_q;
	logic [W-1:0]                  rem_q;
	logic [W-1:0]                  dm_q;
	logic                          neg_q;
	kf2_pkg::fx_t                  val_q;
	logic [W:0]                    trial;
	logic                          ge;
	logic [N-1:0]                  quo_nxt;

	always_comb begin
		trial   = {rem_q, dsr_q[N-1]};
		ge      = trial >= {1'b0, dm_q};
		quo_nxt = {quo_q[N-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (op.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == kf2_pkg::CNT_WIDTH'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.start && !busy_q) begin
			dsr_q <= {kf2_pkg::mag(op.a), {kf2_pkg::FRAC_BITS{1'b0}}};
			dm_q  <= kf2_pkg::mag(op.b);
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= op.a[W-1] ^ op.b[W-1];
		end else if (busy_q) begin
			dsr_q <= dsr_q << 1;
			rem_q <= ge ? W'(trial - {1'b0, dm_q}) : trial[W-1:0];
			quo_q <= quo_nxt;
			val_q <= kf2_pkg::from_mag(neg_q, |quo_nxt[N-1:W], quo_nxt[W-1:0]);
		end
	end

	assign res = '{busy: busy_q, done: done_q, value: val_q};
endmodule

/* sv/two_state_kalman_filter.sv */
// Two-state (position and bias) Kalman filter, top level.
// Depends on kf2_pkg, the channel interfaces, kf2_mul and kf2_div.
//
// The filter handles one item at a time. An init item or an unused kind
// goes straight to the result state without arithmetic, and an update whose
// innovation variance is zero does the same. A predict item runs four products
// through the bit-serial multiplier. An update runs two quotients through the
// restoring divider and five products through the multiplier. The serial
// multiplier and divider take one bit per cycle and are shared by every step
// of the item. The result item is held in an output register until it is
// taken; the next input item is taken only after that. Configuration writes
// are accepted at any time and are meant to happen while the filter is idle.
module two_state_kalman_filter (
	input logic      clk,
	input logic      arst_n,
	kf2_in_if.sink   in_ch,
	kf2_out_if.source out_ch,
	kf2_cfg_if.sink  cfg
);
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	localparam int CW = kf2_pkg::CFG_WIDTH;

	state_t state_q;
	logic [2:0] step_q;
	logic [1:0] kind_q;

	// Configuration registers.
	logic [CW-1:0] time_step_q, meas_noise_q, q_pos_q, q_bias_q, p0_pos_q, p0_bias_q;
	kf2_pkg::fx_t  q_cross_q, p0_cross_q;

	// Filter state and the intermediates of one item.
	kf2_pkg::fx_t pe_q, be_q, vp_q, vc_q, vb_q;
	kf2_pkg::fx_t t_q, y_q, s_q, k0_q, k1_q;

	kf2_pkg::fx_t dt, op_a, op_b, prod, y_new, s_new;
	logic         use_div, last_step;
	kf2_pkg::op_t mul_op, div_op;
	kf2_pkg::res_t mul_res, div_res;
	logic         unit_done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= CW'(kf2_pkg::FX_ONE);
			meas_noise_q <= CW'(kf2_pkg::FX_ONE);
			q_pos_q      <= '0;
			q_cross_q    <= '0;
			q_bias_q     <= '0;
			p0_pos_q     <= CW'(kf2_pkg::FX_ONE);
			p0_cross_q   <= '0;
			p0_bias_q    <= CW'(kf2_pkg::FX_ONE);
		end else if (cfg.valid) begin
			unique case (kf2_pkg::reg_idx_t'(cfg.index))
				kf2_pkg::REG_TIME_STEP:  time_step_q  <= cfg.data[CW-1:0];
				kf2_pkg::REG_MEAS_NOISE: meas_noise_q <= cfg.data[CW-1:0];
				kf2_pkg::REG_Q_POS:      q_pos_q      <= cfg.data[CW-1:0];
				kf2_pkg::REG_Q_CROSS:    q_cross_q    <= cfg.data;
				kf2_pkg::REG_Q_BIAS:     q_bias_q     <= cfg.data[CW-1:0];
				kf2_pkg::REG_P0_POS:     p0_pos_q     <= cfg.data[CW-1:0];
				kf2_pkg::REG_P0_CROSS:   p0_cross_q   <= cfg.data;
				kf2_pkg::REG_P0_BIAS:    p0_bias_q    <= cfg.data[CW-1:0];
				default: ;
			endcase
		end
	end

	assign dt    = {1'b0, time_step_q};
	assign y_new = kf2_pkg::sat_sub(in_ch.measurement, pe_q);
	assign s_new = kf2_pkg::sat_add(vp_q, {1'b0, meas_noise_q});

	// Operands of the current step. The update reorders the covariance steps so
	// that the bias entry still sees the old cross entry.
	always_comb begin
		op_a      = dt;
		op_b      = pe_q;
		use_div   = 1'b0;
		last_step = 1'b0;
		if (kind_q == kf2_pkg::KIND_PREDICT) begin
			case (step_q)
				3'd0:    op_b = vb_q;
				3'd1:    op_b = vc_q;
				3'd2:    op_b = t_q;
				default: begin
					op_b      = be_q;
					last_step = 1'b1;
				end
			endcase
		end else begin
			case (step_q)
				3'd0: begin
					op_a = vp_q; op_b = s_q; use_div = 1'b1;
				end
				3'd1: begin
					op_a = vc_q; op_b = s_q; use_div = 1'b1;
				end
				3'd2: begin
					op_a = k0_q; op_b = y_q;
				end
				3'd3: begin
					op_a = k1_q; op_b = y_q;
				end
				3'd4: begin
					op_a = k0_q; op_b = vp_q;
				end
				3'd5: begin
					op_a = k1_q; op_b = vc_q;
				end
				default: begin
					op_a = k0_q; op_b = vc_q; last_step = 1'b1;
				end
			endcase
		end
	end

	assign mul_op = '{start: (state_q == ST_ISSUE) && !use_div, a: op_a, b: op_b};
	assign div_op = '{start: (state_q == ST_ISSUE) && use_div, a: op_a, b: op_b};

	kf2_mul u_mul (.clk(clk), .arst_n(arst_n), .op(mul_op), .res(mul_res));
	kf2_div u_div (.clk(clk), .arst_n(arst_n), .op(div_op), .res(div_res));

	assign unit_done = use_div ? div_res.done : mul_res.done;
	assign prod      = use_div ? div_res.value : mul_res.value;

	assign in_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			kind_q  <= kf2_pkg::KIND_PREDICT;
			pe_q    <= kf2_pkg::FX_ZERO;
			be_q    <= kf2_pkg::FX_ZERO;
			vp_q    <= kf2_pkg::FX_ONE;
			vc_q    <= kf2_pkg::FX_ZERO;
			vb_q    <= kf2_pkg::FX_ONE;
			t_q     <= kf2_pkg::FX_ZERO;
			y_q     <= kf2_pkg::FX_ZERO;
			s_q     <= kf2_pkg::FX_ZERO;
			k0_q    <= kf2_pkg::FX_ZERO;
			k1_q    <= kf2_pkg::FX_ZERO;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						kind_q <= in_ch.kind;
						step_q <= '0;
						y_q    <= y_new;
						s_q    <= s_new;
						unique case (kf2_pkg::kind_t'(in_ch.kind))
							kf2_pkg::KIND_PREDICT: state_q <= ST_ISSUE;
							kf2_pkg::KIND_UPDATE:
								state_q <= (s_new == kf2_pkg::FX_ZERO) ? ST_OUT : ST_ISSUE;
							kf2_pkg::KIND_INIT: begin
								pe_q    <= in_ch.init_pos;
								be_q    <= in_ch.init_bias;
								vp_q    <= {1'b0, p0_pos_q};
								vc_q    <= p0_cross_q;
								vb_q    <= {1'b0, p0_bias_q};
								state_q <= ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (unit_done) begin
						step_q  <= step_q + 1'b1;
						state_q <= last_step ? ST_OUT : ST_ISSUE;
						if (kind_q == kf2_pkg::KIND_PREDICT) begin
							case (step_q)
								3'd0: t_q  <= kf2_pkg::sat_sub(vc_q, prod);
								3'd1: vp_q <= kf2_pkg::sat_sub(vp_q, prod);
								3'd2: begin
									vp_q <= kf2_pkg::sat_add(kf2_pkg::sat_sub(vp_q, prod),
										{1'b0, q_pos_q});
									vc_q <= kf2_pkg::sat_add(t_q, q_cross_q);
									vb_q <= kf2_pkg::sat_add(vb_q, {1'b0, q_bias_q});
								end
								default: pe_q <= kf2_pkg::sat_sub(pe_q, prod);
							endcase
						end else begin
							case (step_q)
								3'd0:    k0_q <= prod;
								3'd1:    k1_q <= prod;
								3'd2:    pe_q <= kf2_pkg::sat_add(pe_q, prod);
								3'd3:    be_q <= kf2_pkg::sat_add(be_q, prod);
								3'd4:    vp_q <= kf2_pkg::sat_sub(vp_q, prod);
								3'd5:    vb_q <= kf2_pkg::sat_sub(vb_q, prod);
								default: vc_q <= kf2_pkg::sat_sub(vc_q, prod);
							endcase
						end
					end
				end
				ST_OUT: begin
					if (out_ch.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The state registers hold still while the result item waits.
	assign out_ch.valid     = (state_q == ST_OUT);
	assign out_ch.est_pos   = pe_q;
	assign out_ch.est_bias  = be_q;
	assign out_ch.cov_pos   = vp_q;
	assign out_ch.cov_cross = vc_q;
	assign out_ch.cov_bias  = vb_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_res.busy && div_res.busy))
		else $error("multiplier and divider busy together");

	a_wait_has_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> (mul_res.busy || div_res.busy || unit_done))
		else $error("waiting on no arithmetic unit");

	a_issue_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |=> (mul_res.busy || div_res.busy))
		else $error("issued step did not start a unit");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("result shown while taking input");
endmodule

/* bench/kf2_checker.sv */
// Result checker for the two-state Kalman filter: watches the input, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on kf2_pkg and the channel interfaces.
module kf2_checker (
	input logic       clk,
	input logic       arst_n,
	kf2_in_if         in_ch,
	kf2_out_if        out_ch,
	kf2_cfg_if        cfg,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint signed wide_t;

	typedef struct packed {
		kf2_pkg::fx_t est_pos;
		kf2_pkg::fx_t est_bias;
		kf2_pkg::fx_t cov_pos;
		kf2_pkg::fx_t cov_cross;
		kf2_pkg::fx_t cov_bias;
	} filter_out_t;

	localparam wide_t HI = 64'sd2147483647;
	localparam wide_t LO = -64'sd2147483648;

	logic [31:0] regs [8];
	wide_t x_pos, x_bias, p_pos, p_cross, p_bias;
	filter_out_t expected_q [$];

	function automatic wide_t clip(wide_t v);
		if (v > HI) return HI;
		if (v < LO) return LO;
		return v;
	endfunction

	function automatic wide_t fmul(wide_t a, wide_t b);
		logic signed [127:0] p;
		logic [127:0] m;
		p = 128'(signed'(a)) * 128'(signed'(b));
		m = p[127] ? -p : p;
		m = m >> kf2_pkg::FRAC_BITS;
		if (m > 128'(HI)) return p[127] ? LO : HI;
		return p[127] ? -wide_t'(m) : wide_t'(m);
	endfunction

	// Quotient (n << FRAC_BITS) / d, truncated toward zero, then saturated.
	function automatic wide_t fdiv(wide_t n, wide_t d);
		logic [127:0] nm, dm, q;
		logic neg;
		neg = (n < 0) != (d < 0);
		nm = n < 0 ? 128'(-n) : 128'(n);
		dm = d < 0 ? 128'(-d) : 128'(d);
		q = (nm << kf2_pkg::FRAC_BITS) / dm;
		if (q > 128'(HI)) return neg ? LO : HI;
		return neg ? -wide_t'(q) : wide_t'(q);
	endfunction

	function automatic wide_t u31(logic [31:0] r);
		return wide_t'({33'd0, r[30:0]});
	endfunction

	function automatic wide_t s32(logic [31:0] r);
		return wide_t'(signed'(r));
	endfunction

	task automatic advance_filter(logic [1:0] k, kf2_pkg::fx_t z, kf2_pkg::fx_t ip,
		kf2_pkg::fx_t ib);
		wide_t dt, t, a, y, s, k0, k1, c, b;
		filter_out_t r;
		if (k == kf2_pkg::KIND_PREDICT) begin
			dt = u31(regs[kf2_pkg::REG_TIME_STEP]);
			t = clip(p_cross - fmul(dt, p_bias));
			a = clip(p_pos - fmul(dt, p_cross));
			p_pos = clip(clip(a - fmul(dt, t)) + u31(regs[kf2_pkg::REG_Q_POS]));
			p_cross = clip(t + s32(regs[kf2_pkg::REG_Q_CROSS]));
			p_bias = clip(p_bias + u31(regs[kf2_pkg::REG_Q_BIAS]));
			x_pos = clip(x_pos - fmul(dt, x_bias));
		end else if (k == kf2_pkg::KIND_UPDATE) begin
			y = clip(wide_t'(z) - x_pos);
			s = clip(p_pos + u31(regs[kf2_pkg::REG_MEAS_NOISE]));
			if (s != 0) begin
				k0 = fdiv(p_pos, s);
				k1 = fdiv(p_cross, s);
				a = p_pos;
				c = p_cross;
				b = p_bias;
				x_pos = clip(x_pos + fmul(k0, y));
				x_bias = clip(x_bias + fmul(k1, y));
				p_pos = clip(a - fmul(k0, a));
				p_cross = clip(c - fmul(k0, c));
				p_bias = clip(b - fmul(k1, c));
			end
		end else if (k == kf2_pkg::KIND_INIT) begin
			x_pos = ip;
			x_bias = ib;
			p_pos = u31(regs[kf2_pkg::REG_P0_POS]);
			p_cross = s32(regs[kf2_pkg::REG_P0_CROSS]);
			p_bias = u31(regs[kf2_pkg::REG_P0_BIAS]);
		end
		r.est_pos = kf2_pkg::fx_t'(x_pos);
		r.est_bias = kf2_pkg::fx_t'(x_bias);
		r.cov_pos = kf2_pkg::fx_t'(p_pos);
		r.cov_cross = kf2_pkg::fx_t'(p_cross);
		r.cov_bias = kf2_pkg::fx_t'(p_bias);
		expected_q.push_back(r);
	endtask

	task automatic report(string what, kf2_pkg::fx_t want, kf2_pkg::fx_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		filter_out_t want;
		if (!arst_n) begin
			regs[kf2_pkg::REG_TIME_STEP] <= 32'h10000;
			regs[kf2_pkg::REG_MEAS_NOISE] <= 32'h10000;
			regs[kf2_pkg::REG_Q_POS] <= 0;
			regs[kf2_pkg::REG_Q_CROSS] <= 0;
			regs[kf2_pkg::REG_Q_BIAS] <= 0;
			regs[kf2_pkg::REG_P0_POS] <= 32'h10000;
			regs[kf2_pkg::REG_P0_CROSS] <= 0;
			regs[kf2_pkg::REG_P0_BIAS] <= 32'h10000;
			x_pos = 0;
			x_bias = 0;
			p_pos = 65536;
			p_cross = 0;
			p_bias = 65536;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				regs[cfg.index] <= cfg.data;
			if (in_ch.valid && in_ch.ready)
				advance_filter(in_ch.kind, in_ch.measurement, in_ch.init_pos, in_ch.init_bias);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result item with nothing expected", $realtime);
				end else begin
					want = expected_q.pop_front();
					if (out_ch.est_pos !== want.est_pos)
						report("est_pos", want.est_pos, out_ch.est_pos);
					if (out_ch.est_bias !== want.est_bias)
						report("est_bias", want.est_bias, out_ch.est_bias);
					if (out_ch.cov_pos !== want.cov_pos)
						report("cov_pos", want.cov_pos, out_ch.cov_pos);
					if (out_ch.cov_cross !== want.cov_cross)
						report("cov_cross", want.cov_cross, out_ch.cov_cross);
					if (out_ch.cov_bias !== want.cov_bias)
						report("cov_bias", want.cov_bias, out_ch.cov_bias);
				end
			end
			pending = expected_q.size();
		end
	end
endmodule

/* bench/tb.sv */
// Testbench top for the two-state Kalman filter: clock, reset, configuration
// phases, directed and random input items and the verdict.
// Depends on kf2_pkg, the channel interfaces, kf2_checker and the filter RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count;
	int pending;

	// The receiver stall modes: 0 never stalls, 1 stalls at random,
	// 2 holds off for a long counted stretch.
	int stall_mode = 0;
	bit send_in_bursts = 1'b1;

	kf2_in_if in_ch ();
	kf2_out_if out_ch ();
	kf2_cfg_if cfg ();

	two_state_kalman_filter dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
	);

	kf2_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
		.fail_count(fail_count), .pending(pending)
	);

	always #10 clk = ~clk;

	// Safety net: the slowest item is an update; all items of the run, with random
	// stalls, fit easily in this bound.
	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end

	// Receiver: ready changes only at the falling edge.
	initial begin
		int hold;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_mode == 2) begin
				// Hold off long enough that the filter sits on a finished
				// result and refuses new input items.
				out_ch.ready <= 1'b0;
				for (hold = 0; hold < 900; hold++)
					@(negedge clk);
				out_ch.ready <= 1'b1;
				stall_mode = 1;
			end else if (stall_mode == 1)
				out_ch.ready <= ($urandom_range(0, 3) != 0);
			else
				out_ch.ready <= 1'b1;
		end
	end

	// Write one register through the configuration channel. Ready only
	// changes at a rising edge, so its value at a falling edge holds for the
	// next rising edge.
	task automatic write_reg(kf2_pkg::reg_idx_t idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		while (!cfg.ready) @(negedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Offer one input item and hold it until the filter takes it. Between
	// items the sender may leave a random gap, which ends a burst.
	task automatic send_item(logic [1:0] k, kf2_pkg::fx_t z, kf2_pkg::fx_t ip,
		kf2_pkg::fx_t ib);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.measurement <= z;
		in_ch.init_pos <= ip;
		in_ch.init_bias <= ib;
		while (!in_ch.ready) @(negedge clk);
		@(negedge clk);
		if (send_in_bursts && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			gap = $urandom_range(1, 40);
			repeat (gap) @(negedge clk);
		end
	endtask

	// Wait for every expected result, then give an item that finishes with
	// no visible trace a little extra time before touching the registers.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic kf2_pkg::fx_t rand_fx();
		case ($urandom_range(0, 5))
			0: return kf2_pkg::FX_MAX;
			1: return kf2_pkg::FX_MIN;
			2: return kf2_pkg::fx_t'($urandom_range(0, 1 << 20)) - kf2_pkg::fx_t'(1 << 19);
			default: return kf2_pkg::fx_t'($urandom());
		endcase
	endfunction

	// Random item: mostly small steps that keep the filter in a sane range,
	// with occasional wild measurements and initial states.
	task automatic random_item();
		int pick;
		kf2_pkg::fx_t z;
		pick = $urandom_range(0, 99);
		z = ($urandom_range(0, 3) == 0) ? rand_fx()
			: kf2_pkg::fx_t'($urandom_range(0, 1 << 22)) - kf2_pkg::fx_t'(1 << 21);
		if (pick < 40)
			send_item(kf2_pkg::KIND_PREDICT, rand_fx(), rand_fx(), rand_fx());
		else if (pick < 85)
			send_item(kf2_pkg::KIND_UPDATE, z, rand_fx(), rand_fx());
		else if (pick < 95)
			send_item(kf2_pkg::KIND_INIT, rand_fx(), rand_fx(), rand_fx());
		else
			send_item(kf2_pkg::KIND_NONE, rand_fx(), rand_fx(), rand_fx());
	endtask

	task automatic random_config();
		write_reg(kf2_pkg::REG_TIME_STEP, $urandom_range(0, 1 << 17));
		write_reg(kf2_pkg::REG_MEAS_NOISE, $urandom_range(0, 1 << 19));
		write_reg(kf2_pkg::REG_Q_POS, $urandom_range(0, 1 << 14));
		write_reg(kf2_pkg::REG_Q_CROSS, $urandom_range(0, 1 << 14) - (1 << 13));
		write_reg(kf2_pkg::REG_Q_BIAS, $urandom_range(0, 1 << 12));
		write_reg(kf2_pkg::REG_P0_POS, $urandom_range(0, 1 << 20));
		write_reg(kf2_pkg::REG_P0_CROSS, $urandom_range(0, 1 << 16) - (1 << 15));
		write_reg(kf2_pkg::REG_P0_BIAS, $urandom_range(0, 1 << 20));
	endtask

	initial begin
		int phase;
		int n;
		in_ch.valid = 1'b0;
		in_ch.kind = kf2_pkg::KIND_PREDICT;
		in_ch.measurement = '0;
		in_ch.init_pos = '0;
		in_ch.init_bias = '0;
		cfg.valid = 1'b0;
		cfg.index = kf2_pkg::REG_TIME_STEP;
		cfg.data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under reset settings: every kind, field extremes and an
		// unused kind.
		send_item(kf2_pkg::KIND_PREDICT, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		send_item(kf2_pkg::KIND_UPDATE, kf2_pkg::FX_MAX, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		send_item(kf2_pkg::KIND_UPDATE, kf2_pkg::FX_MIN, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		send_item(kf2_pkg::KIND_NONE, kf2_pkg::FX_MAX, kf2_pkg::FX_MIN, kf2_pkg::FX_MAX);
		send_item(kf2_pkg::KIND_INIT, kf2_pkg::FX_ZERO, kf2_pkg::FX_MAX, kf2_pkg::FX_MIN);
		send_item(kf2_pkg::KIND_PREDICT, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		send_item(kf2_pkg::KIND_INIT, kf2_pkg::FX_ZERO, kf2_pkg::FX_MIN, kf2_pkg::FX_MAX);
		send_item(kf2_pkg::KIND_PREDICT, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		send_item(kf2_pkg::KIND_UPDATE, kf2_pkg::FX_ONE, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		drain();

		// Extreme settings: largest step, noise and initial variances, and the most
		// negative cross process noise.
		write_reg(kf2_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
		write_reg(kf2_pkg::REG_MEAS_NOISE, 32'h7FFF_FFFF);
		write_reg(kf2_pkg::REG_Q_POS, 32'h7FFF_FFFF);
		write_reg(kf2_pkg::REG_Q_CROSS, 32'h8000_0000);
		write_reg(kf2_pkg::REG_Q_BIAS, 32'h7FFF_FFFF);
		write_reg(kf2_pkg::REG_P0_POS, 32'h7FFF_FFFF);
		write_reg(kf2_pkg::REG_P0_CROSS, 32'h7FFF_FFFF);
		write_reg(kf2_pkg::REG_P0_BIAS, 32'h7FFF_FFFF);
		send_item(kf2_pkg::KIND_INIT, kf2_pkg::FX_ZERO, kf2_pkg::FX_MAX, kf2_pkg::FX_MIN);
		send_item(kf2_pkg::KIND_PREDICT, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		send_item(kf2_pkg::KIND_UPDATE, kf2_pkg::FX_MIN, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		send_item(kf2_pkg::KIND_UPDATE, kf2_pkg::FX_MAX, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		drain();

		write_reg(kf2_pkg::REG_TIME_STEP, 32'd0);
		write_reg(kf2_pkg::REG_MEAS_NOISE, 32'h0001_0000);
		write_reg(kf2_pkg::REG_Q_CROSS, 32'h7FFF_FFFF);
		write_reg(kf2_pkg::REG_P0_POS, 32'd0);
		write_reg(kf2_pkg::REG_P0_CROSS, 32'h8000_0000);
		write_reg(kf2_pkg::REG_P0_BIAS, 32'd0);
		send_item(kf2_pkg::KIND_INIT, kf2_pkg::FX_ZERO, kf2_pkg::FX_ONE, -kf2_pkg::FX_ONE);
		send_item(kf2_pkg::KIND_PREDICT, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		send_item(kf2_pkg::KIND_UPDATE, kf2_pkg::FX_ONE, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		drain();

		// Zero innovation variance: r = 0 and P00 = 0.
		write_reg(kf2_pkg::REG_MEAS_NOISE, 32'd0);
		send_item(kf2_pkg::KIND_INIT, kf2_pkg::FX_ZERO, kf2_pkg::FX_ONE, kf2_pkg::FX_ONE);
		send_item(kf2_pkg::KIND_UPDATE, kf2_pkg::FX_MAX, kf2_pkg::FX_ZERO, kf2_pkg::FX_ZERO);
		drain();

		// Random phases with fresh settings in each.
		for (phase = 0; phase < 6; phase++) begin
			random_config();
			stall_mode = (phase == 2) ? 2 : (phase == 0 ? 0 : 1);
			send_in_bursts = (phase != 4);
			send_item(kf2_pkg::KIND_INIT, kf2_pkg::FX_ZERO, rand_fx() >>> 8, rand_fx() >>> 8);
			for (n = 0; n < 85; n++)
				random_item();
			drain();
		end

		stall_mode = 0;
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
